/* sv/stbs_pkg.sv */
package stbs_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    // Range bounds run from 0 to TABLE_DEPTH inclusive
    localparam int RANGE_W     = ADDR_W + 1;

    // Field widths fixed by the interface
    localparam int COUNT_W = 11;
    localparam int INDEX_W = 10;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 10;

    // Operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic [INDEX_W-1:0]       entry_index;
        logic signed [DATA_W-1:0] data_value;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP
    } t_state;

endpackage

/* sv/stbs_ram.sv */
module stbs_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write or read one word per cycle, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

/* sv/sorted_table_binary_search_top.sv */
// Sorted table with binary search.
// Input channel: an item is taken at a clock edge where start is high and
// busy is low. A write item (operation 0) stores data_value at entry_index
// in the same edge; writes at an index beyond the table are dropped. A
// write gives no result and leaves busy low, so writes go one per cycle.
// A search item (operation 1) looks for data_value among the first
// element_count entries, which must be written and sorted ascending (signed).
// Result channel: o_done is high for exactly one cycle with o_result; the
// receiver always takes it. Each probe passes through ST_PROBE (the
// single-port table read) and ST_CMP (the compare); a search makes at most
// floor(log2(element_count))+1 probes. An empty table answers without a
// probe. busy stays high during the search and is low again in the o_done
// cycle, so the next item can be taken then.
// Configuration: the user must write element_count with i_cfg_we only
// while the block is idle; the block itself does not enforce this.
// Values above the table depth are saturated to the depth.
// Reset clears element_count and the controller; the table contents are
// undefined until written, and no clearing pass runs.
module sorted_table_binary_search_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  stbs_pkg::t_in_item             i_item,
    output logic                           o_done,
    output stbs_pkg::t_out_item            o_result,
    input  logic                           i_cfg_we,
    input  logic [stbs_pkg::COUNT_W-1:0]   i_cfg_wdata
);

    stbs_pkg::t_state r_state, n_state;

    logic [stbs_pkg::COUNT_W-1:0]       r_count;
    logic [stbs_pkg::RANGE_W-1:0]       r_lo, n_lo;
    logic [stbs_pkg::RANGE_W-1:0]       r_hi, n_hi;
    logic [stbs_pkg::RANGE_W-1:0]       r_mid;
    logic [stbs_pkg::RANGE_W-1:0]       mid;
    logic [stbs_pkg::RANGE_W-1:0]       count_sat;
    logic signed [stbs_pkg::DATA_W-1:0] r_target;
    logic signed [stbs_pkg::DATA_W-1:0] probe;
    logic [stbs_pkg::DATA_W-1:0]        rdata;
    logic                               r_done;
    stbs_pkg::t_out_item                r_result;

    logic                               accept;
    logic                               acc_write;
    logic                               acc_search;
    logic                               hit;
    logic                               go_left;
    logic                               range_empty;
    logic                               ram_we;
    logic [stbs_pkg::ADDR_W-1:0]        ram_addr;

    assign accept     = start && !busy;
    assign acc_write  = accept && (i_item.operation == stbs_pkg::OP_WRITE);
    assign acc_search = accept && (i_item.operation == stbs_pkg::OP_SEARCH);

    // Saturate the entry count to the table depth
    assign count_sat = (32'(r_count) > stbs_pkg::TABLE_DEPTH)
                     ? stbs_pkg::RANGE_W'(stbs_pkg::TABLE_DEPTH)
                     : stbs_pkg::RANGE_W'(r_count);

    // Midpoint of the half-open range [lo, hi), rounding down
    assign mid = r_lo + ((r_hi - r_lo - stbs_pkg::RANGE_W'(1)) >> 1);

    // Compare the returned entry with the target
    assign probe       = $signed(rdata);
    assign hit         = (probe == r_target);
    assign go_left     = (r_target < probe);
    assign range_empty = (n_lo >= n_hi);

    // Table port: writes only while idle, probe reads during a search
    assign ram_we   = acc_write && (32'(i_item.entry_index) < stbs_pkg::TABLE_DEPTH);
    assign ram_addr = (r_state == stbs_pkg::ST_PROBE)
                    ? mid[stbs_pkg::ADDR_W-1:0]
                    : stbs_pkg::ADDR_W'(i_item.entry_index);

    stbs_ram #(
        .DEPTH (stbs_pkg::TABLE_DEPTH),
        .WIDTH (stbs_pkg::DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_item.data_value),
        .o_rdata (rdata)
    );

    // Narrow the range after a miss
    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (go_left) begin
            n_hi = r_mid;
        end else begin
            n_lo = r_mid + stbs_pkg::RANGE_W'(1);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stbs_pkg::ST_IDLE: begin
                if (acc_search && (count_sat != '0)) begin
                    n_state = stbs_pkg::ST_PROBE;
                end
            end
            stbs_pkg::ST_PROBE: begin
                n_state = stbs_pkg::ST_CMP;
            end
            stbs_pkg::ST_CMP: begin
                if (hit || range_empty) begin
                    n_state = stbs_pkg::ST_IDLE;
                end else begin
                    n_state = stbs_pkg::ST_PROBE;
                end
            end
            default: n_state = stbs_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        busy     = (r_state != stbs_pkg::ST_IDLE);
        o_done   = r_done;
        o_result = r_result;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stbs_pkg::ST_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            r_done <= (acc_search && (count_sat == '0))
                   || ((r_state == stbs_pkg::ST_CMP) && (hit || range_empty));
        end
    end

    // Search datapath and result
    always_ff @(posedge i_clk) begin
        if (acc_search) begin
            r_lo     <= '0;
            r_hi     <= count_sat;
            r_target <= i_item.data_value;
            r_result <= '0;
        end
        if (r_state == stbs_pkg::ST_PROBE) begin
            r_mid <= mid;
        end
        if (r_state == stbs_pkg::ST_CMP) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
            if (hit) begin
                r_result.found    <= 1'b1;
                r_result.position <= stbs_pkg::POS_W'(r_mid);
            end else begin
                r_result <= '0;
            end
        end
    end

endmodule

/* sv/stbs_checker.sv */
module stbs_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input stbs_pkg::t_in_item           i_item,
    input logic                         o_done,
    input stbs_pkg::t_out_item          o_result
);

    // A result never shows while a search is still running
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_done && busy))
        else $error("result strobe while busy");

    // A miss reports position zero
    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.found) |-> (o_result.position == '0))
        else $error("miss with nonzero position");

    // A write item gives no result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.operation == stbs_pkg::OP_WRITE)) |=> !o_done)
        else $error("result after write item");

    // A search item either starts work or answers at once
    a_search_acts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.operation == stbs_pkg::OP_SEARCH)) |=> (busy || o_done))
        else $error("search item dropped");

    // The end of a search delivers its result
    a_end_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("search ended without result");

endmodule

bind sorted_table_binary_search_top stbs_checker u_stbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_item      (i_item),
    .o_done      (o_done),
    .o_result    (o_result)
);

/* dv/tb.sv */
`timescale 1ns / 1ps

// Scoreboard: keeps its own copy of the table and the count, predicts the
// answer of every accepted search and checks the answers in order.
class search_checker;
    logic signed [stbs_pkg::DATA_W-1:0] entry_words[stbs_pkg::TABLE_DEPTH];
    bit                                 written[stbs_pkg::TABLE_DEPTH];
    logic [stbs_pkg::COUNT_W-1:0]       count_setting;
    stbs_pkg::t_out_item                awaited_answers[$];
    int                                 failures;
    int                                 writes_seen;
    int                                 searches_seen;
    int                                 hits_seen;

    function new();
        foreach (entry_words[k]) begin
            entry_words[k] = '0;
            written[k]     = 1'b0;
        end
        count_setting = '0;
        failures      = 0;
        writes_seen   = 0;
        searches_seen = 0;
        hits_seen     = 0;
    endfunction

    function void set_count(logic [stbs_pkg::COUNT_W-1:0] value);
        count_setting = value;
    endfunction

    function int pending();
        return awaited_answers.size();
    endfunction

    // Walk the probe path; the return flag tells whether every probed entry
    // has been written.
    function bit search_table(input logic signed [stbs_pkg::DATA_W-1:0] target,
                              output stbs_pkg::t_out_item answer);
        int lo;
        int hi;
        int mid;
        int span;
        bit all_written;
        bit hit;
        all_written = 1'b1;
        hit         = 1'b0;
        answer      = '0;
        span = (int'(count_setting) > stbs_pkg::TABLE_DEPTH) ?
               stbs_pkg::TABLE_DEPTH : int'(count_setting);
        lo = 0;
        hi = span - 1;
        while (!hit && lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (!written[stbs_pkg::ADDR_W'(mid)]) begin
                all_written = 1'b0;
            end
            if (entry_words[stbs_pkg::ADDR_W'(mid)] == target) begin
                hit             = 1'b1;
                answer.found    = 1'b1;
                answer.position = stbs_pkg::POS_W'(mid);
            end else if (target < entry_words[stbs_pkg::ADDR_W'(mid)]) begin
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        return all_written;
    endfunction

    // Apply a write, or queue the answer a search must give
    function void note_item(stbs_pkg::t_in_item item);
        stbs_pkg::t_out_item answer;
        if (item.operation == stbs_pkg::OP_WRITE) begin
            entry_words[item.entry_index] = item.data_value;
            written[item.entry_index]     = 1'b1;
            writes_seen++;
        end else begin
            void'(search_table(item.data_value, answer));
            awaited_answers.push_back(answer);
            searches_seen++;
            if (answer.found) begin
                hits_seen++;
            end
        end
    endfunction

    // Compare one answer from the block against the oldest prediction
    function void check_answer(stbs_pkg::t_out_item got);
        stbs_pkg::t_out_item want;
        if (awaited_answers.size() == 0) begin
            if (failures < 10) begin
                $display("Unexpected answer: found=%0d position=%0d",
                         got.found, got.position);
            end
            failures++;
            return;
        end
        want = awaited_answers.pop_front();
        if (got.found !== want.found || got.position !== want.position) begin
            if (failures < 10) begin
                $display("Mismatch: expected found=%0d position=%0d, got found=%0d position=%0d",
                         want.found, want.position, got.found, got.position);
            end
            failures++;
        end
    endfunction
endclass

module tb;

    localparam int RUN_LIMIT       = 1000000;
    localparam int SETTLE_CYCLES   = 30;
    localparam int RANDOM_SEARCHES = 160;
    // Spans up to this size are written in full; larger ones only along
    // the probe paths that the searches take
    localparam int EAGER_SPAN      = 32;
    localparam int BIG_SPAN        = 256;

    localparam logic signed [stbs_pkg::DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [stbs_pkg::DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    stbs_pkg::t_in_item           i_item;
    logic                         o_done;
    stbs_pkg::t_out_item          o_result;
    logic                         i_cfg_we;
    logic [stbs_pkg::COUNT_W-1:0] i_cfg_wdata;

    search_checker board = new();
    bit            steady;
    int            cycles = 0;
    int            settings_used;

    // Value each entry is meant to hold in the current phase
    logic signed [stbs_pkg::DATA_W-1:0] plan_words[stbs_pkg::TABLE_DEPTH];

    sorted_table_binary_search_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Check every answer in the cycle its strobe is high
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            board.check_answer(o_result);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("Timed out after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones, none in steady stretches
    function automatic int pick_gap();
        int roll;
        if (steady) begin
            return 0;
        end
        roll = int'($urandom_range(99));
        if (roll < 55) begin
            return 0;
        end
        if (roll < 90) begin
            return int'($urandom_range(3, 1));
        end
        return int'($urandom_range(40, 8));
    endfunction

    // Hold start with the item until the block takes it
    task automatic send_item(input stbs_pkg::t_in_item item);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= item;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_item(item);
    endtask

    task automatic send_write(input logic [stbs_pkg::INDEX_W-1:0] idx,
                              input logic signed [stbs_pkg::DATA_W-1:0] value);
        stbs_pkg::t_in_item item;
        item.operation   = stbs_pkg::OP_WRITE;
        item.entry_index = idx;
        item.data_value  = value;
        plan_words[idx]  = value;
        send_item(item);
    endtask

    // Bring every entry on the probe path to its planned value
    task automatic write_path(input logic signed [stbs_pkg::DATA_W-1:0] target);
        int                                 lo;
        int                                 hi;
        int                                 mid;
        int                                 span;
        bit                                 hit;
        logic signed [stbs_pkg::DATA_W-1:0] word;
        span = (int'(board.count_setting) > stbs_pkg::TABLE_DEPTH) ?
               stbs_pkg::TABLE_DEPTH : int'(board.count_setting);
        hit = 1'b0;
        lo  = 0;
        hi  = span - 1;
        while (!hit && lo <= hi) begin
            mid  = lo + (hi - lo) / 2;
            word = plan_words[stbs_pkg::ADDR_W'(mid)];
            if (!board.written[stbs_pkg::ADDR_W'(mid)] ||
                board.entry_words[stbs_pkg::ADDR_W'(mid)] !== word) begin
                send_write(stbs_pkg::INDEX_W'(mid), word);
            end
            if (word == target) begin
                hit = 1'b1;
            end else if (target < word) begin
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
    endtask

    // Fill in the probe path, then send the search; drop any search that
    // would still probe an entry never written
    task automatic send_search(input logic signed [stbs_pkg::DATA_W-1:0] target);
        stbs_pkg::t_in_item  item;
        stbs_pkg::t_out_item probe_answer;
        item.operation   = stbs_pkg::OP_SEARCH;
        item.entry_index = stbs_pkg::INDEX_W'($urandom());
        item.data_value  = target;
        write_path(target);
        if (board.search_table(target, probe_answer)) begin
            send_item(item);
        end
    endtask

    // Let the block drain, then write the count register
    task automatic set_count(input logic [stbs_pkg::COUNT_W-1:0] value);
        start <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_count(value);
        settings_used++;
    endtask

    // Plan entries 0..span-1: sorted with spread values, sorted and dense
    // (many duplicates), or scrambled; write small spans at once
    task automatic fill_entries(input int span);
        longint                             level;
        longint                             stride;
        int                                 style;
        int                                 k;
        logic signed [stbs_pkg::DATA_W-1:0] word;
        style = int'($urandom_range(9));
        if (style < 3) begin
            stride = longint'($urandom_range(4, 1));
            level  = -64'sd2147483648 + longint'($urandom_range(32'hFFFF_EFFF));
        end else begin
            stride = 64'sd4294967296 / (span + 1);
            level  = -64'sd2147483648 + longint'($urandom_range(32'(stride - 1)));
        end
        for (k = 0; k < span; k++) begin
            if (style == 9) begin
                word = $urandom();
            end else begin
                if (k > 0 && $urandom_range(7) != 0) begin
                    level = level + longint'($urandom_range(32'(stride)));
                end
                word = level[stbs_pkg::DATA_W-1:0];
            end
            if (span <= EAGER_SPAN) begin
                send_write(stbs_pkg::INDEX_W'(k), word);
            end else begin
                plan_words[stbs_pkg::ADDR_W'(k)] = word;
            end
        end
    endtask

    // Targets: present values, near misses, random words and extremes
    function automatic logic signed [stbs_pkg::DATA_W-1:0] pick_target(input int span);
        int                                 roll;
        logic signed [stbs_pkg::DATA_W-1:0] near;
        roll = int'($urandom_range(99));
        if (span == 0 || roll < 15) begin
            return $urandom();
        end
        near = plan_words[stbs_pkg::ADDR_W'($urandom_range(span - 1))];
        if (roll < 65) begin
            return near;
        end
        if (roll < 85) begin
            return $urandom_range(1) ? near + 32'sd1 : near - 32'sd1;
        end
        case ($urandom_range(3))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return 32'sd0;
            default: return -32'sd1;
        endcase
    endfunction

    // Pick the count for one random phase; the first phases hit the extremes
    function automatic logic [stbs_pkg::COUNT_W-1:0] pick_count(input int phase);
        int roll;
        if (phase == 0) begin
            return stbs_pkg::COUNT_W'(stbs_pkg::TABLE_DEPTH);
        end
        if (phase == 1) begin
            return '1;
        end
        if (phase == 2) begin
            return '0;
        end
        roll = int'($urandom_range(99));
        if (roll < 65) begin
            return stbs_pkg::COUNT_W'($urandom_range(24, 1));
        end
        if (roll < 82) begin
            return stbs_pkg::COUNT_W'($urandom_range(200, 25));
        end
        if (roll < 97) begin
            return stbs_pkg::COUNT_W'($urandom_range(3, 0));
        end
        return stbs_pkg::COUNT_W'($urandom_range(2047, 1025));
    endfunction

    initial begin
        int phase;
        int span;
        int quota;
        int n;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_item      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        settings_used = 0;
        steady      = 1'b0;
        foreach (plan_words[k]) begin
            plan_words[k] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table, then the lowest and highest index and value
        set_count('0);
        send_search(32'sd0);
        send_search(WORD_MAX);
        send_write('1, WORD_MAX);
        send_write('0, WORD_MIN);
        set_count(stbs_pkg::COUNT_W'(1));
        send_search(WORD_MIN);
        send_search(WORD_MAX);
        send_search(32'sd0);
        send_write(stbs_pkg::INDEX_W'(1), WORD_MAX);
        set_count(stbs_pkg::COUNT_W'(2));
        send_search(WORD_MIN);
        send_search(WORD_MAX);
        send_search(-32'sd1);

        // Run of duplicates: the first equal entry on the path wins
        send_write(stbs_pkg::INDEX_W'(0), 32'sd5);
        send_write(stbs_pkg::INDEX_W'(1), 32'sd5);
        send_write(stbs_pkg::INDEX_W'(2), 32'sd5);
        set_count(stbs_pkg::COUNT_W'(3));
        send_search(32'sd5);
        send_search(32'sd4);
        send_search(32'sd6);

        // Unsorted table still follows the same probe path
        send_write(stbs_pkg::INDEX_W'(0), 32'sd9);
        send_write(stbs_pkg::INDEX_W'(1), 32'sd1);
        send_write(stbs_pkg::INDEX_W'(2), 32'sd4);
        send_search(32'sd4);
        send_search(32'sd9);
        send_search(32'sd1);

        // Random phases: new count, fresh contents, then mostly searches
        phase = 0;
        while (board.searches_seen < RANDOM_SEARCHES) begin
            steady = 1'b0;
            set_count(pick_count(phase));
            span = (int'(board.count_setting) > stbs_pkg::TABLE_DEPTH) ?
                   stbs_pkg::TABLE_DEPTH : int'(board.count_setting);
            steady = ($urandom_range(3) == 0);
            fill_entries(span);
            quota = (span > BIG_SPAN) ? int'($urandom_range(10, 6))
                                      : int'($urandom_range(40, 20));
            for (n = 0; n < quota; n++) begin
                if ($urandom_range(9) == 0) begin
                    if (span > 0 && $urandom_range(1) != 0) begin
                        send_write(stbs_pkg::INDEX_W'($urandom_range(span - 1)),
                                   pick_target(span));
                    end else begin
                        send_write(stbs_pkg::INDEX_W'($urandom()), $urandom());
                    end
                end else begin
                    send_search(pick_target(span));
                end
            end
            phase++;
        end

        // Drain and let any stray answer show up
        start <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d writes and %0d searches (%0d hits) across %0d count settings",
                 board.writes_seen, board.searches_seen, board.hits_seen, settings_used);
        $display("Answer failures: %0d", board.failures);
        if (board.failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
